// ===== rtl/core/ccmp_pkg.sv =====
// ----------------------------------------------------------------------------
// CCMP packet number package
// Widths, codes, item types and header packing helpers that the CCMP packet
// number modules share.
// ----------------------------------------------------------------------------
package ccmp_pkg;

   localparam int QUEUES  = 16;
   localparam int QUEUE_W = 4;
   localparam int QIDX_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int PN_W    = 48;
   localparam int HDR_W   = 64;
   localparam int CNT_W   = 32;
   localparam int KID_W   = 2;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 152;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index as carried in paddr bit 2.
   localparam logic REG_KEY_INDEX = 1'b0;

   // Extended IV flag in header byte three.
   localparam logic [7:0] EXT_IV_BIT = 8'h20;

   typedef enum logic {
      KIND_TX = 1'b0,
      KIND_RX = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT    = 2'd0,
      VERDICT_REPLAY    = 2'd1,
      VERDICT_UNCHECKED = 2'd2,
      VERDICT_AUTH_FAIL = 2'd3
   } verdict_type;

   typedef struct packed {
      kind_type             kind;
      logic [QUEUE_W-1:0]   queue;
      logic [HDR_W-1:0]     header;
      logic                 stripped;
      logic                 auth_ok;
   } req_item_type;

   typedef struct packed {
      verdict_type          verdict;
      logic [HDR_W-1:0]     header_out;
      logic [PN_W-1:0]      packet_number;
      logic [KID_W-1:0]     key_id_seen;
      logic [CNT_W-1:0]     replay_total;
   } rsp_item_type;

   // Header bytes from low to high: PN0, PN1, 0, flags, PN2..PN5.
   function automatic logic [HDR_W-1:0] pn_to_header(input logic [PN_W-1:0]  pn,
                                                     input logic [KID_W-1:0] kid);
      logic [7:0] flags;
      flags = EXT_IV_BIT | {kid, 6'b0};
      return {pn[47:16], flags, 8'h00, pn[15:0]};
   endfunction

   function automatic logic [PN_W-1:0] header_to_pn(input logic [HDR_W-1:0] hdr);
      return {hdr[63:32], hdr[15:0]};
   endfunction

endpackage

// ===== rtl/core/ccmp_csr.sv =====
// ----------------------------------------------------------------------------
// CCMP control register
// APB-style register file holding the transmit key index.
// ----------------------------------------------------------------------------
module ccmp_csr
   import ccmp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [KID_W-1:0]      key_index
);

   logic [KID_W-1:0] key_index_ff;
   logic [KID_W-1:0] key_index_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      key_index_in = key_index_ff;
      if (wr_en && (csr_paddr[2] == REG_KEY_INDEX)) begin
         key_index_in = csr_pwdata[KID_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_index_ff <= '0;
      end else begin
         key_index_ff <= key_index_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_KEY_INDEX) begin
         csr_prdata = {{(CSR_DATA_W-KID_W){1'b0}}, key_index_ff};
      end
   end

   assign key_index = key_index_ff;

endmodule

// ===== rtl/core/ccmp_pn_core.sv =====
// ----------------------------------------------------------------------------
// CCMP packet number core
// Holds the transmit PN, the per-queue receive PN table and the replay
// counter, and decides one item per firing cycle.
// ----------------------------------------------------------------------------
module ccmp_pn_core
   import ccmp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  req_item_type     item,
   input  logic [KID_W-1:0] key_index,
   output rsp_item_type     result
);

   logic [PN_W-1:0]   tx_pn_ff;
   logic [PN_W-1:0]   tx_pn_in;
   logic [PN_W-1:0]   rx_pn_ff [QUEUES];
   logic [CNT_W-1:0]  replay_ff;
   logic [CNT_W-1:0]  replay_in;
   logic [QIDX_W-1:0] qidx;
   logic [PN_W-1:0]   rx_pn;
   logic              rx_write;

   // Queue numbers past the table use its last entry.
   always_comb begin
      if ({1'b0, item.queue} >= (QUEUE_W+1)'(QUEUES)) begin
         qidx = QIDX_W'(QUEUES - 1);
      end else begin
         qidx = item.queue[QIDX_W-1:0];
      end
   end

   assign rx_pn = header_to_pn(item.header);

   always_comb begin
      tx_pn_in              = tx_pn_ff;
      replay_in             = replay_ff;
      rx_write              = 1'b0;
      result.verdict        = VERDICT_ACCEPT;
      result.header_out     = '0;
      result.packet_number  = '0;
      result.key_id_seen    = '0;
      unique case (item.kind)
         KIND_TX: begin
            tx_pn_in             = tx_pn_ff + PN_W'(1);
            result.packet_number = tx_pn_in;
            result.header_out    = pn_to_header(tx_pn_in, key_index);
         end
         KIND_RX: begin
            if (item.stripped) begin
               result.verdict = VERDICT_UNCHECKED;
            end else begin
               result.packet_number = rx_pn;
               result.key_id_seen   = item.header[31:30];
               priority if (rx_pn <= rx_pn_ff[qidx]) begin
                  replay_in      = replay_ff + CNT_W'(1);
                  result.verdict = VERDICT_REPLAY;
               end else if (!item.auth_ok) begin
                  result.verdict = VERDICT_AUTH_FAIL;
               end else begin
                  rx_write = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      result.replay_total = replay_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_pn_ff  <= '0;
         replay_ff <= '0;
         for (int i = 0; i < QUEUES; i++) begin
            rx_pn_ff[i] <= '0;
         end
      end else if (fire) begin
         tx_pn_ff  <= tx_pn_in;
         replay_ff <= replay_in;
         if (rx_write) begin
            rx_pn_ff[qidx] <= rx_pn;
         end
      end
   end

   a_tx_advance : assert property (@(posedge clock) disable iff (reset)
      fire && (item.kind == KIND_TX) |=> tx_pn_ff == $past(tx_pn_ff) + PN_W'(1))
      else $error("transmit PN did not advance by one");

   a_replay_only : assert property (@(posedge clock) disable iff (reset)
      fire && (result.verdict != VERDICT_REPLAY) |=> $stable(replay_ff))
      else $error("replay counter moved without a replay");

   a_accept_store : assert property (@(posedge clock) disable iff (reset)
      fire && (item.kind == KIND_RX) && (result.verdict == VERDICT_ACCEPT)
      |=> rx_pn_ff[$past(qidx)] == $past(rx_pn))
      else $error("accepted PN not stored for its queue");

   a_rx_no_tx : assert property (@(posedge clock) disable iff (reset)
      fire && (item.kind == KIND_RX) |=> $stable(tx_pn_ff))
      else $error("receive transfer changed the transmit PN");

endmodule

// ===== rtl/core/ccmp_packet_number_replay_check.sv =====
// ----------------------------------------------------------------------------
// CCMP packet number and replay check
// Builds transmit CCMP headers from a running PN and checks received PNs
// against a per-queue table of stored PNs, counting replays in one counter.
// ----------------------------------------------------------------------------
// An accepted request transfer goes through the input register and then the
// result register to rsp_tvalid. Throughput: one transfer per cycle while
// rsp_tready allows; the core's PN compare and increment sit between them.
// Reset (synchronous, active high) clears the transmit PN, all receive PN
// entries, the replay counter and the key index at once; no clearing pass.
module ccmp_packet_number_replay_check
   import ccmp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Fields from bit 0 up: queue[3:0], header_in[67:4], hw_stripped[68],
   // auth_ok[69], zero fill[71:70].
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0 up: kind[0].
   input  logic [0:0]             req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0 up: verdict[1:0], header_out[65:2],
   // packet_number[113:66], key_id_seen[115:114], replay_total[147:116],
   // zero fill[151:148].
   output logic [RSP_TDATA_W-1:0] rsp_tdata,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic             in_valid_ff;
   logic             in_valid_in;
   req_item_type     in_item_ff;
   req_item_type     in_item_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   rsp_item_type     out_item_ff;
   rsp_item_type     out_item_in;
   rsp_item_type     core_result;
   logic [KID_W-1:0] key_index;
   logic             req_xfer;
   logic             advance;
   logic             fire;

   ccmp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key_index   (key_index)
   );

   // The result register frees up when it is empty or its transfer completes
   // this cycle. The input register moves into it then, and the input
   // register takes a new transfer whenever it is empty or moving, so a
   // request is taken even while a result still waits downstream.
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_item_in.kind     = kind_type'(req_tuser[0]);
      in_item_in.queue    = req_tdata[3:0];
      in_item_in.header   = req_tdata[67:4];
      in_item_in.stripped = req_tdata[68];
      in_item_in.auth_ok  = req_tdata[69];
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // State updates happen in the core at the same edge that loads the result
   // register, so the next item already sees the updated PN values.
   ccmp_pn_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_item_ff),
      .key_index (key_index),
      .result    (core_result)
   );

   assign out_item_in = core_result;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= in_item_in;
      end
      if (fire) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0,
                        out_item_ff.replay_total,
                        out_item_ff.key_id_seen,
                        out_item_ff.packet_number,
                        out_item_ff.header_out,
                        out_item_ff.verdict};

endmodule

// ===== verif/tb_ccmp_packet_number_replay_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CCMP packet number replay check testbench
// This testbench sends transmit and receive transfers into the block. It
// predicts every result from its own copy of the transmit PN, the PN table
// of each queue, the replay counter and the key index, and compares each
// result transfer field by field. The key index is rewritten between phases.
// Both stream sides idle at random, and the receiver holds off once for a
// long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_ccmp_packet_number_replay_check;
   import ccmp_pkg::*;

   // The longest correct stretch without any transfer is the long receiver
   // hold, plus latency and idling. This limit is several times that.
   localparam int WATCHDOG_LIMIT   = 2000;
   // Pause after the last result before a register write or the end.
   // It is longer than the latency of the block.
   localparam int DRAIN_CYCLES     = 6;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int LONG_HOLD_AFTER  = 300;
   localparam int PHASE_ITEMS      = 260;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // Fields from bit 0 up: queue[3:0], header_in[67:4], hw_stripped[68],
   // auth_ok[69], zero fill[71:70].
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // Fields from bit 0 up: kind[0].
   logic [0:0]             req_tuser = '0;

   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // Fields from bit 0 up: verdict[1:0], header_out[65:2],
   // packet_number[113:66], key_id_seen[115:114], replay_total[147:116],
   // zero fill[151:148].
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   ccmp_packet_number_replay_check uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Requests waiting for the driver, and results predicted for the
   // requests that the block has taken, oldest first.
   req_item_type     pending_requests[$];
   rsp_item_type     predicted_results[$];

   // Predicted state of the block, as it stands after reset.
   logic [PN_W-1:0]  tx_pn_model = '0;
   logic [PN_W-1:0]  rx_pn_model [QUEUES] = '{default: '0};
   logic [CNT_W-1:0] replay_count_model = '0;
   logic [KID_W-1:0] key_index_model = '0;

   // The stimulus' own idea of the highest PN that each queue has stored.
   // Sequences are built on top of it so that most of them are fresh.
   logic [PN_W-1:0]  sent_pn [QUEUES] = '{default: '0};

   int               mismatches = 0;
   int               results_seen = 0;
   logic             quiet = 1'b0;

   // Works out the result of one request and advances the predicted state.
   function automatic rsp_item_type replay_check_predict(input req_item_type item);
      rsp_item_type    res;
      int unsigned     slot;
      logic [PN_W-1:0] pn;
      res = '0;
      res.verdict = VERDICT_ACCEPT;
      if (item.kind == KIND_TX) begin
         // The counter goes up first, so the first header carries PN 1.
         tx_pn_model = tx_pn_model + 1'b1;
         res.packet_number     = tx_pn_model;
         res.header_out[15:0]  = tx_pn_model[15:0];
         res.header_out[31:24] = {key_index_model, 6'b0} | EXT_IV_BIT;
         res.header_out[63:32] = tx_pn_model[47:16];
      end else if (item.stripped) begin
         // The header is gone, so there is nothing to check or store.
         res.verdict = VERDICT_UNCHECKED;
      end else begin
         slot = (item.queue >= QUEUES) ? QUEUES - 1 : item.queue;
         pn = {item.header[63:56], item.header[55:48], item.header[47:40],
               item.header[39:32], item.header[15:8], item.header[7:0]};
         res.packet_number = pn;
         res.key_id_seen   = item.header[31:30];
         // A replay is reported even when the MIC check failed as well.
         if (pn <= rx_pn_model[slot]) begin
            replay_count_model = replay_count_model + 1'b1;
            res.verdict = VERDICT_REPLAY;
         end else if (!item.auth_ok) begin
            res.verdict = VERDICT_AUTH_FAIL;
         end else begin
            rx_pn_model[slot] = pn;
         end
      end
      res.replay_total = replay_count_model;
      return res;
   endfunction

   // Transmit request; the fields that it ignores get random values.
   task automatic push_tx();
      req_item_type item;
      item.kind     = KIND_TX;
      item.queue    = 4'($urandom);
      item.header   = {$urandom, $urandom};
      item.stripped = 1'($urandom);
      item.auth_ok  = 1'($urandom);
      pending_requests.push_back(item);
   endtask

   // Receive request; byte 2 and the low six flag bits are random, since the
   // block must not look at them.
   task automatic push_rx(input int q, input logic [PN_W-1:0] pn,
                          input logic [KID_W-1:0] kid, input logic stripped,
                          input logic auth);
      req_item_type item;
      item.kind           = KIND_RX;
      item.queue          = 4'(q);
      item.stripped       = stripped;
      item.auth_ok        = auth;
      item.header         = {$urandom, $urandom};
      item.header[15:0]   = pn[15:0];
      item.header[31:30]  = kid;
      item.header[63:32]  = pn[47:16];
      if (!stripped && auth && pn > sent_pn[q])
         sent_pn[q] = pn;
      pending_requests.push_back(item);
   endtask

   // Mostly fresh PNs a little above the stored one, then replays, jumps and
   // fully random PNs as noise.
   task automatic push_random_rx();
      int              q;
      int              pick;
      logic [PN_W-1:0] base;
      logic [PN_W-1:0] pn;
      q    = $urandom_range(QUEUES - 1);
      base = sent_pn[q];
      pick = $urandom_range(99);
      if (pick < 60)
         pn = base + $urandom_range(1, 3);
      else if (pick < 75)
         pn = base - ((base > 2) ? $urandom_range(0, 2) : 0);
      else if (pick < 85)
         pn = base + 48'($urandom) + 1'b1;
      else
         pn = {16'($urandom), $urandom};
      push_rx(q, pn, 2'($urandom_range(3)), $urandom_range(99) < 8,
              $urandom_range(99) < 85);
   endtask

   // Returns once every request is taken and every result has come back.
   task automatic wait_drain();
      while (pending_requests.size() != 0 || req_tvalid || predicted_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write in a setup phase and then an access phase. The register
   // takes the value as the access ends, since pready is always high.
   task automatic write_key_index(input logic [KID_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_KEY_INDEX, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      key_index_model = value;
   endtask

   task automatic run_random_phase(input int count);
      repeat (count) begin
         if ($urandom_range(99) < 30)
            push_tx();
         else
            push_random_rx();
      end
      wait_drain();
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] seen);
      if (seen !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
         mismatches++;
      end
   endtask

   // Driver. A new request goes out only when the slot is free, that is when
   // nothing is offered or the current request transfers at this edge. The
   // request that transfers is predicted right here, in acceptance order.
   req_item_type req_current;
   int           send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            predicted_results.push_back(replay_check_predict(req_current));
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() != 0 && !quiet &&
                      $urandom_range(9) == 0) begin
            // Random idle burst.
            send_gap = $urandom_range(0, 3);
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            req_current = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {2'b00, req_current.auth_ok, req_current.stripped,
                           req_current.header, req_current.queue};
            req_tuser  <= req_current.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver ready. Short stall bursts at random, and once in the run a long
   // hold-off while the sender keeps offering, which backs the block up.
   int   stall_left = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= LONG_HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(7) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor. Every result transfer is unpacked and held against the oldest
   // prediction.
   always @(posedge clock) begin
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.verdict       = verdict_type'(rsp_tdata[1:0]);
         seen.header_out    = rsp_tdata[65:2];
         seen.packet_number = rsp_tdata[113:66];
         seen.key_id_seen   = rsp_tdata[115:114];
         seen.replay_total  = rsp_tdata[147:116];
         if (predicted_results.size() == 0) begin
            $error("result transfer with no prediction waiting: 0x%0h", rsp_tdata);
            mismatches++;
         end else begin
            want = predicted_results.pop_front();
            check_field("verdict", 64'(want.verdict), 64'(seen.verdict));
            check_field("header_out", want.header_out, seen.header_out);
            check_field("packet_number", 64'(want.packet_number),
                        64'(seen.packet_number));
            check_field("key_id_seen", 64'(want.key_id_seen), 64'(seen.key_id_seen));
            check_field("replay_total", 64'(want.replay_total),
                        64'(seen.replay_total));
         end
         results_seen++;
      end
   end

   // Watchdog on cycles in which neither side transfers anything.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Transmit headers under the key index that reset leaves.
      push_tx();
      push_tx();
      wait_drain();

      write_key_index(2'd3);
      push_tx();
      // The stored PN after reset is zero, so PN zero is already a replay.
      push_rx(0, 48'd0, 2'd0, 1'b0, 1'b1);
      // Fresh PN with a failed MIC: dropped, and the stored PN stays.
      push_rx(0, 48'd1, 2'd3, 1'b0, 1'b0);
      push_rx(0, 48'd1, 2'd3, 1'b0, 1'b1);
      // Equal to the stored PN counts as a replay.
      push_rx(0, 48'd1, 2'd1, 1'b0, 1'b1);
      // Stripped headers pass unchecked, whatever they carry.
      push_rx(0, 48'd0, 2'd2, 1'b1, 1'b0);
      push_rx(7, '1, 2'd3, 1'b1, 1'b1);
      // Largest PN on the last queue, then replay before auth failure.
      push_rx(15, '1, 2'd3, 1'b0, 1'b1);
      push_rx(15, '1, 2'd3, 1'b0, 1'b0);
      push_rx(15, 48'd0, 2'd0, 1'b0, 1'b0);
      // Compares that hinge on the top bit and on the PN2 byte.
      push_rx(3, 48'h8000_0000_0000, 2'd2, 1'b0, 1'b1);
      push_rx(3, 48'h7FFF_FFFF_FFFF, 2'd1, 1'b0, 1'b1);
      push_rx(8, 48'h0000_0001_0000, 2'd0, 1'b0, 1'b1);
      push_rx(8, 48'h0000_0000_FFFF, 2'd0, 1'b0, 1'b1);
      push_tx();
      wait_drain();

      // Random phases, each under its own key index. The long receiver hold
      // falls into the second one.
      write_key_index(2'd0);
      run_random_phase(PHASE_ITEMS);
      write_key_index(2'd1);
      run_random_phase(PHASE_ITEMS);
      write_key_index(2'd2);
      run_random_phase(PHASE_ITEMS);
      write_key_index(2'($urandom_range(3)));
      run_random_phase(PHASE_ITEMS);
      // The last part runs with both sides at full rate.
      quiet <= 1'b1;
      write_key_index(2'd3);
      run_random_phase(PHASE_ITEMS);

      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== ccmp_packet_number_replay_check.f =====
rtl/core/ccmp_pkg.sv
rtl/core/ccmp_csr.sv
rtl/core/ccmp_pn_core.sv
rtl/core/ccmp_packet_number_replay_check.sv
verif/tb_ccmp_packet_number_replay_check.sv
